/* sv/cpu8_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cpu8_pkg;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] addr;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [7:0] pc;
    logic       halted;
    logic [1:0] fault;
    logic       screen_valid;
    logic [7:0] screen_byte;
    logic [7:0] read_data;
  } result_t;

  localparam logic [2:0] CMD_WRITE_MEM = 3'd0;
  localparam logic [2:0] CMD_SET_PC    = 3'd1;
  localparam logic [2:0] CMD_STEP      = 3'd2;
  localparam logic [2:0] CMD_READ_REG  = 3'd3;
  localparam logic [2:0] CMD_READ_MEM  = 3'd4;

  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_IMM   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADD   = 4'h5;
  localparam logic [3:0] OP_FADD  = 4'h6;
  localparam logic [3:0] OP_OR    = 4'h7;
  localparam logic [3:0] OP_AND   = 4'h8;
  localparam logic [3:0] OP_XOR   = 4'h9;
  localparam logic [3:0] OP_ROT   = 4'hA;
  localparam logic [3:0] OP_JEQ   = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hC;
  localparam logic [3:0] OP_JLT   = 4'hD;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_PC     = 2'd2;

  localparam logic [7:0] PC_RESET = 8'd16;
  localparam logic [7:0] PC_LIMIT = 8'd254;

  typedef struct packed {
    logic load;
    logic wr_mem_cmd;
    logic set_pc;
    logic ovf_fault;
    logic rd_cap;
    logic fetch_lo;
    logic fetch_hi;
    logic fetch_cap;
    logic cap_a;
    logic cap_b;
    logic fstep;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] op;
    logic       halted;
    logic       pc_ovf;
    logic       fnorm_done;
  } status_t;

endpackage
`default_nettype wire

/* sv/cpu8_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpu8_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* sv/cpu8_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpu8_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire cpu8_pkg::status_t status,
  output cpu8_pkg::ctl_t         ctl,
  output logic                   busy,
  output logic                   done
);
  import cpu8_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_RDCAP = 10'b0000000100,
    S_FHI   = 10'b0000001000,
    S_FCAP  = 10'b0000010000,
    S_CAPA  = 10'b0000100000,
    S_CAPB  = 10'b0001000000,
    S_FNORM = 10'b0010000000,
    S_EXEC  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_DONE;
        case (status.cmd)
          CMD_WRITE_MEM: ctl.wr_mem_cmd = 1'b1;
          CMD_SET_PC: ctl.set_pc = 1'b1;
          CMD_READ_REG, CMD_READ_MEM: state_next = S_RDCAP;
          CMD_STEP: begin
            if (!status.halted) begin
              if (status.pc_ovf) begin
                ctl.ovf_fault = 1'b1;
              end else begin
                ctl.fetch_lo = 1'b1;
                state_next = S_FHI;
              end
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RDCAP: begin
        ctl.rd_cap = 1'b1;
        state_next = S_DONE;
      end
      S_FHI: begin
        ctl.fetch_hi = 1'b1;
        state_next = S_FCAP;
      end
      S_FCAP: begin
        ctl.fetch_cap = 1'b1;
        state_next = S_CAPA;
      end
      S_CAPA: begin
        ctl.cap_a = 1'b1;
        state_next = S_CAPB;
      end
      S_CAPB: begin
        ctl.cap_b = 1'b1;
        state_next = (status.op == OP_FADD) ? S_FNORM : S_EXEC;
      end
      S_FNORM: begin
        if (status.fnorm_done) begin
          state_next = S_EXEC;
        end else begin
          ctl.fstep = 1'b1;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
endmodule
`default_nettype wire

/* sv/cpu8_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpu8_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cpu8_pkg::request_t request,
  input  wire logic               start_address_we,
  input  wire logic [7:0]         start_address,
  input  wire cpu8_pkg::ctl_t     ctl,
  output cpu8_pkg::status_t       status,
  output cpu8_pkg::result_t       result
);
  import cpu8_pkg::*;

  request_t    req;
  logic [7:0]  pc, b0, b1, opa, memb, scr_byte, rd;
  logic        halt, scr_valid;
  logic [1:0]  fault;
  logic [12:0] fmag;
  logic [2:0]  fexp;
  logic        fsign;

  logic [255:0] mvld;
  logic [15:0]  rvld;
  logic         mvq, rvq;
  logic [7:0]   mem_addr, mem_wdata, mem_raw, mem_q;
  logic         mem_we;
  logic [3:0]   rf_addr;
  logic [7:0]   rf_wdata, rf_raw, rf_q;
  logic         rf_we;

  logic [3:0]  op, fop;
  logic [3:0]  slot_a, slot_b, wr_slot;
  logic [11:0] fa, fb;
  logic [12:0] fsum, fdiff, fdiff_r;
  logic        a_ge;
  logic [7:0]  fres;
  logic [15:0] rot2;
  logic        jump, op_fault;

  assign op  = b0[7:4];
  assign fop = mem_q[7:4];

  always_comb begin
    slot_a = ((op >= OP_MOVE) && (op <= OP_XOR)) ? mem_q[7:4] : b0[3:0];
    slot_b = ((op == OP_JEQ) || (op == OP_JLT)) ? 4'd0 : b1[3:0];
    wr_slot = (op == OP_MOVE) ? b1[3:0] : b0[3:0];
  end

  always_comb begin
    if (ctl.fetch_lo) begin
      mem_addr = pc;
    end else if (ctl.fetch_hi) begin
      mem_addr = pc + 8'd1;
    end else if (ctl.fetch_cap) begin
      mem_addr = mem_q;
    end else if (ctl.exec) begin
      mem_addr = b1;
    end else begin
      mem_addr = req.addr;
    end
    if (ctl.fetch_cap) begin
      rf_addr = slot_a;
    end else if (ctl.cap_a || ctl.cap_b) begin
      rf_addr = slot_b;
    end else if (ctl.exec) begin
      rf_addr = wr_slot;
    end else begin
      rf_addr = req.addr[3:0];
    end
  end

  always_comb begin
    fa = {7'd0, 1'b1, opa[3:0]} << opa[6:4];
    fb = {7'd0, 1'b1, rf_q[3:0]} << rf_q[6:4];
    fsum = {1'b0, fa} + {1'b0, fb};
    fdiff = {1'b0, fa} - {1'b0, fb};
    a_ge = (fa >= fb);
    fdiff_r = a_ge ? fdiff : ({1'b0, fb} - {1'b0, fa});
    if (fmag[12]) begin
      fres = {fsign, 7'h7F};
    end else if (fmag[11:4] == 8'd0) begin
      fres = 8'h00;
    end else begin
      fres = {fsign, fexp, fmag[10:7]};
    end
    rot2 = {opa, opa} >> b1[2:0];
  end

  always_comb begin
    rf_we = 1'b0;
    rf_wdata = opa;
    mem_we = ctl.wr_mem_cmd;
    mem_wdata = req.data;
    jump = 1'b0;
    op_fault = 1'b0;
    if (ctl.exec) begin
      unique case (op)
        OP_LOAD: begin
          rf_we = 1'b1;
          rf_wdata = memb;
        end
        OP_IMM: begin
          rf_we = 1'b1;
          rf_wdata = b1;
        end
        OP_STORE: begin
          mem_we = 1'b1;
          mem_wdata = opa;
        end
        OP_MOVE: rf_we = 1'b1;
        OP_ADD: begin
          rf_we = 1'b1;
          rf_wdata = opa + rf_q;
        end
        OP_FADD: begin
          rf_we = 1'b1;
          rf_wdata = fres;
        end
        OP_OR: begin
          rf_we = 1'b1;
          rf_wdata = opa | rf_q;
        end
        OP_AND: begin
          rf_we = 1'b1;
          rf_wdata = opa & rf_q;
        end
        OP_XOR: begin
          rf_we = 1'b1;
          rf_wdata = opa ^ rf_q;
        end
        OP_ROT: begin
          rf_we = 1'b1;
          rf_wdata = rot2[7:0];
        end
        OP_JEQ: jump = (rf_q == opa);
        OP_JLT: jump = (rf_q < opa);
        OP_HALT: op_fault = 1'b0;
        default: op_fault = 1'b1;
      endcase
    end
  end

  cpu8_ram #(.Width(8), .Depth(256)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_raw)
  );

  cpu8_ram #(.Width(8), .Depth(16)) u_rf (
    .clk(clk), .we(rf_we), .addr(rf_addr), .wdata(rf_wdata), .rdata(rf_raw)
  );

  assign mem_q = mvq ? mem_raw : 8'd0;
  assign rf_q  = rvq ? rf_raw : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= '0;
      rvld <= '0;
      mvq <= 1'b0;
      rvq <= 1'b0;
      pc <= PC_RESET;
      halt <= 1'b0;
      fault <= FAULT_NONE;
    end else begin
      mvq <= mvld[mem_addr];
      rvq <= rvld[rf_addr];
      if (mem_we) begin
        mvld[mem_addr] <= 1'b1;
      end
      if (rf_we) begin
        rvld[rf_addr] <= 1'b1;
      end
      if (start_address_we) begin
        pc <= start_address;
      end else if (ctl.set_pc) begin
        pc <= req.addr;
        halt <= 1'b0;
        fault <= FAULT_NONE;
      end else if (ctl.ovf_fault) begin
        halt <= 1'b1;
        fault <= FAULT_PC;
      end else if (ctl.fetch_cap) begin
        pc <= pc + 8'd2;
      end else if (ctl.exec) begin
        if (jump) begin
          pc <= b1;
        end
        if (op == OP_HALT) begin
          halt <= 1'b1;
        end
        if (op_fault) begin
          halt <= 1'b1;
          fault <= FAULT_OPCODE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req <= request;
      scr_valid <= 1'b0;
      scr_byte <= 8'd0;
      rd <= 8'd0;
    end
    if (ctl.rd_cap) begin
      rd <= (req.cmd == CMD_READ_REG) ? rf_q : mem_q;
    end
    if (ctl.fetch_hi) begin
      b0 <= mem_q;
    end
    if (ctl.fetch_cap) begin
      b1 <= mem_q;
    end
    if (ctl.cap_a) begin
      opa <= rf_q;
      memb <= mem_q;
    end
    if (ctl.cap_b) begin
      fexp <= 3'd7;
      if (opa[7] == rf_q[7]) begin
        fmag <= fsum;
        fsign <= opa[7];
      end else begin
        fmag <= fdiff_r;
        fsign <= a_ge ? opa[7] : rf_q[7];
      end
    end
    if (ctl.fstep) begin
      fmag <= {fmag[11:0], 1'b0};
      fexp <= fexp - 3'd1;
    end
    if (ctl.exec && (op == OP_STORE) && (b1 == 8'd0)) begin
      scr_valid <= 1'b1;
      scr_byte <= opa;
    end
  end

  always_comb begin
    status.cmd = req.cmd;
    status.op = (ctl.fetch_cap) ? fop : op;
    status.halted = halt;
    status.pc_ovf = (pc >= PC_LIMIT);
    status.fnorm_done = fmag[12] || fmag[11] || (fmag[11:4] == 8'd0);
    result.pc = pc;
    result.halted = halt;
    result.fault = fault;
    result.screen_valid = scr_valid;
    result.screen_byte = scr_byte;
    result.read_data = rd;
  end
endmodule
`default_nettype wire

/* sv/eight_bit_teaching_cpu.sv */
// A step runs through dispatch, fetch, operand capture and execute before the done strobe,
// plus normalizing steps in S_FNORM for a mini-float add until the sum is normalized.
// Throughput: one item at a time; busy is high until the cycle after done.
// Reset is synchronous: registers and memory read as zero, the pc loads 16.
// Each result is shown for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module eight_bit_teaching_cpu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire cpu8_pkg::request_t request,
  input  wire logic               start_address_we,
  input  wire logic [7:0]         start_address,
  output logic                    done,
  output cpu8_pkg::result_t       result
);
  import cpu8_pkg::*;

  ctl_t    ctl;
  status_t status;

  cpu8_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status),
    .ctl(ctl), .busy(busy), .done(done)
  );

  cpu8_dp u_dp (
    .clk(clk), .rst(rst), .request(request),
    .start_address_we(start_address_we), .start_address(start_address),
    .ctl(ctl), .status(status), .result(result)
  );

`ifndef ASSERT_OFF
  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item not taken");
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (done && (result.fault != FAULT_NONE)) |-> result.halted)
    else $error("fault without halt");
`endif
endmodule
`default_nettype wire
